// ----- design/dads_pkg.sv -----
package dads_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CENT_W   = 8;
    localparam int unsigned YLO_W    = 7;

    localparam int unsigned DAY_COUNT_BITS_DEF = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DEC_DAYS  = 5'd31;
    localparam logic [YLO_W-1:0]   YLO_LAST  = 7'd99;

    // Century split: year / 100 == (year * 5243) >> 19 for every 14-bit year.
    localparam int unsigned        CENT_MUL_W = 27;
    localparam logic [12:0]        CENT_RECIP = 13'd5243;
    localparam int unsigned        CENT_SHIFT = 19;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd2;

    typedef struct packed {
        logic load;
        logic split;
        logic check;
        logic step;
        logic out_load;
    } t_dads_cmd;

    typedef struct packed {
        logic                step_done;
        logic                step_ovf;
        logic [STATUS_W-1:0] chk_code;
    } t_dads_sts;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd4:      len = 5'd30;
            4'd6:      len = 5'd30;
            4'd9:      len = 5'd30;
            4'd11:     len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- design/dads_datapath.sv -----
module dads_datapath import dads_pkg::*; #(
    parameter int unsigned DAY_COUNT_BITS = DAY_COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dads_cmd                 i_cmd,
    output t_dads_sts                 o_sts,
    input  logic                      i_op,
    input  logic [YEAR_W-1:0]         i_start_year,
    input  logic [MONTH_W-1:0]        i_start_month,
    input  logic [DAY_W-1:0]          i_start_day,
    input  logic [DAY_COUNT_BITS-1:0] i_day_count,
    output logic [YEAR_W-1:0]         o_result_year,
    output logic [MONTH_W-1:0]        o_result_month,
    output logic [DAY_W-1:0]          o_result_day,
    output logic [STATUS_W-1:0]       o_status
);

    logic                      r_op;
    logic [YEAR_W-1:0]         r_sy;
    logic [MONTH_W-1:0]        r_sm;
    logic [DAY_W-1:0]          r_sd;
    logic [DAY_COUNT_BITS-1:0] r_cnt;
    logic [YEAR_W-1:0]         r_y;
    logic [MONTH_W-1:0]        r_m;
    logic [DAY_W-1:0]          r_d;
    logic [CENT_W-1:0]         r_century;
    logic [YLO_W-1:0]          r_lo;
    logic [STATUS_W-1:0]       r_status;
    logic [YEAR_W-1:0]         r_res_y;
    logic [MONTH_W-1:0]        r_res_m;
    logic [DAY_W-1:0]          r_res_d;
    logic [STATUS_W-1:0]       r_res_status;

    logic [CENT_MUL_W-1:0]     cent_prod;
    logic [YEAR_W:0]           cent_x100;
    logic [YEAR_W:0]           year_rem;
    logic                      leap;
    logic [DAY_W-1:0]          cur_len;
    logic [DAY_W-1:0]          room;
    logic [DAY_W:0]            room_plus;
    logic                      add_fits;
    logic                      sub_fits;
    logic [STATUS_W-1:0]       chk_code;

    assign cent_prod = CENT_MUL_W'(i_start_year) * CENT_MUL_W'(CENT_RECIP);
    assign cent_x100 = {1'b0, r_century, 6'b0} + {2'b0, r_century, 5'b0}
                     + {5'b0, r_century, 2'b0};
    assign year_rem  = {1'b0, r_y} - cent_x100;

    // Divisible by 4, and either not a whole century or a century divisible by 4.
    assign leap    = (r_lo[1:0] == 2'b00)
                   && ((r_lo != '0) || (r_century[1:0] == 2'b00));
    assign cur_len = month_days(r_m, leap);

    assign room      = cur_len - r_d;
    assign room_plus = {1'b0, room} + (DAY_W+1)'(1);
    assign add_fits  = r_cnt <= DAY_COUNT_BITS'(room);
    assign sub_fits  = r_cnt <  DAY_COUNT_BITS'(r_d);

    always_comb begin
        if ((r_m == '0) || (r_m > MONTH_DEC) || (r_d == '0) || (r_d > cur_len)) begin
            chk_code = ST_BAD_DATE;
        end else if (r_y > YEAR_MAX) begin
            chk_code = ST_RANGE;
        end else begin
            chk_code = ST_OK;
        end
    end

    assign o_sts.chk_code  = chk_code;
    assign o_sts.step_done = r_op ? sub_fits : add_fits;
    assign o_sts.step_ovf  = !o_sts.step_done
                           && (r_op ? ((r_m == MONTH_JAN) && (r_y == '0))
                                    : ((r_m == MONTH_DEC) && (r_y == YEAR_MAX)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_sy      <= i_start_year;
            r_sm      <= i_start_month;
            r_sd      <= i_start_day;
            r_y       <= i_start_year;
            r_m       <= i_start_month;
            r_d       <= i_start_day;
            r_cnt     <= i_day_count;
            r_century <= cent_prod[CENT_SHIFT +: CENT_W];
        end

        if (i_cmd.split) begin
            r_lo <= year_rem[YLO_W-1:0];
        end

        if (i_cmd.check) begin
            r_status <= chk_code;
        end

        if (i_cmd.step) begin
            if (o_sts.step_done) begin
                r_d <= r_op ? (r_d - r_cnt[DAY_W-1:0]) : (r_d + r_cnt[DAY_W-1:0]);
            end else if (o_sts.step_ovf) begin
                r_status <= ST_RANGE;
            end else if (!r_op) begin
                // Jump to the first of the next month.
                r_cnt <= r_cnt - DAY_COUNT_BITS'(room_plus);
                r_d   <= DAY_W'(1);
                if (r_m == MONTH_DEC) begin
                    r_m <= MONTH_JAN;
                    r_y <= r_y + YEAR_W'(1);
                    if (r_lo == YLO_LAST) begin
                        r_lo      <= '0;
                        r_century <= r_century + CENT_W'(1);
                    end else begin
                        r_lo <= r_lo + YLO_W'(1);
                    end
                end else begin
                    r_m <= r_m + MONTH_W'(1);
                end
            end else begin
                // Jump to the last day of the previous month.
                r_cnt <= r_cnt - DAY_COUNT_BITS'(r_d);
                if (r_m == MONTH_JAN) begin
                    r_m <= MONTH_DEC;
                    r_d <= DEC_DAYS;
                    r_y <= r_y - YEAR_W'(1);
                    if (r_lo == '0) begin
                        r_lo      <= YLO_LAST;
                        r_century <= r_century - CENT_W'(1);
                    end else begin
                        r_lo <= r_lo - YLO_W'(1);
                    end
                end else begin
                    r_m <= r_m - MONTH_W'(1);
                    r_d <= month_days(r_m - MONTH_W'(1), leap);
                end
            end
        end

        if (i_cmd.out_load) begin
            r_res_status <= r_status;
            if (r_status == ST_OK) begin
                r_res_y <= r_y;
                r_res_m <= r_m;
                r_res_d <= r_d;
            end else begin
                r_res_y <= r_sy;
                r_res_m <= r_sm;
                r_res_d <= r_sd;
            end
        end
    end

    assign o_result_year  = r_res_y;
    assign o_result_month = r_res_m;
    assign o_result_day   = r_res_d;
    assign o_status       = r_res_status;

    a_month_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_m >= MONTH_JAN) && (r_m <= MONTH_DEC))
        else $error("working month left 1..12 after a step");

    a_year_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_y <= YEAR_MAX))
        else $error("working year passed 9999 while stepping");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && o_sts.step_done |=> (r_d != '0) && (r_d <= $past(cur_len)))
        else $error("final day falls outside the month");

endmodule

// ----- design/dads_ctrl.sv -----
module dads_ctrl import dads_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_dads_cmd o_cmd,
    input  t_dads_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_CHECK,
        S_STEP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.split    = (r_state == S_SPLIT);
    assign o_cmd.check    = (r_state == S_CHECK);
    assign o_cmd.step     = (r_state == S_STEP);
    assign o_cmd.out_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SPLIT;
            S_SPLIT:  n_state = S_CHECK;
            S_CHECK:  n_state = (i_sts.chk_code == ST_OK) ? S_STEP : S_FINISH;
            S_STEP:   if (i_sts.step_done || i_sts.step_ovf) n_state = S_FINISH;
            S_FINISH: if (o_cmd.out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.out_load))
        else $error("result shown without a result register load");

endmodule

// ----- design/date_add_subtract_days.sv -----
// Gregorian date plus or minus a day count.
//
// Input stream (s_axis): one transfer carries a start date, a day count and the
// operation in tuser (0 add, 1 subtract). Output stream (m_axis): one transfer
// per input with the resulting date and a status code in tuser (0 ok, 1 year
// out of range, 2 invalid start date). On a range error or a bad date the start
// date is returned unchanged.
//
// One item is handled at a time. The result becomes valid once the month-stepping
// loop has crossed every month boundary covered by the day count; a bad date or a
// start year past 9999 skips the loop. s_axis_tready is high only while the block
// is idle, so a new item is taken only after the result of the last one has been
// loaded into the output register.
//
// A result waits in the output register while the receiver stalls; the next
// input can be taken meanwhile, but its result is held back until the output
// register is free. A synchronous reset returns the controller to idle and
// drops m_axis_tvalid.
module date_add_subtract_days import dads_pkg::*; #(
    parameter int unsigned DAY_COUNT_BITS = DAY_COUNT_BITS_DEF,
    localparam int unsigned IN_BITS  = YEAR_W + MONTH_W + DAY_W + DAY_COUNT_BITS,
    localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_BITS = YEAR_W + MONTH_W + DAY_W,
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_year, start_month, start_day, day_count, zero fill
    input  logic [IN_W-1:0]     s_axis_tdata,
    // op
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // result_year, result_month, result_day, zero fill
    output logic [OUT_W-1:0]    m_axis_tdata,
    // status
    output logic [STATUS_W-1:0] m_axis_tuser
);

    t_dads_cmd           cmd;
    t_dads_sts           sts;
    logic [YEAR_W-1:0]   res_year;
    logic [MONTH_W-1:0]  res_month;
    logic [DAY_W-1:0]    res_day;

    dads_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dads_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (s_axis_tuser),
        .i_start_year   (s_axis_tdata[0 +: YEAR_W]),
        .i_start_month  (s_axis_tdata[YEAR_W +: MONTH_W]),
        .i_start_day    (s_axis_tdata[YEAR_W + MONTH_W +: DAY_W]),
        .i_day_count    (s_axis_tdata[YEAR_W + MONTH_W + DAY_W +: DAY_COUNT_BITS]),
        .o_result_year  (res_year),
        .o_result_month (res_month),
        .o_result_day   (res_day),
        .o_status       (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({res_day, res_month, res_year});

endmodule
